// ----- rtl/bitmap_set_count_scan_top_defines.svh -----
// assertion macros for the bit map block
// no dependencies; included by the top level only
`ifndef BITMAP_SET_COUNT_SCAN_TOP_DEFINES_SVH
`define BITMAP_SET_COUNT_SCAN_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BSSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/bssc_pkg.sv -----
// shared types and constants of the bit map block
// no dependencies
package bssc_pkg;

    localparam int FIELD_W       = 13;
    localparam int MAX_BITS_DEF  = 4096;
    localparam int WORD_BITS_DEF = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int GRP_W         = 8;

    localparam logic [FIELD_W-1:0] BITS_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_IN_USE = 2'd0,
        CFG_ONE_BASED   = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_SCAN  = 2'd3
    } action_t;

    typedef struct packed {
        logic               bit_out;
        logic [FIELD_W-1:0] ones_total;
        logic               found;
        logic [FIELD_W-1:0] found_position;
        logic               range_error;
    } result_t;

endpackage

// ----- rtl/bitmap_set_count_scan_top.sv -----
// bit map with running count of ones and ascending set-bit scan
// uses bssc_pkg, bssc_wdiv, bssc_ffs and bitmap_set_count_scan_top_defines.svh
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------------
//  cfg     | cfg_valid/ready    | cfg_index, cfg_data
//  s       | s_valid/s_ready    | action, bit_index, bit_in, fill_count, scan_restart
//  m       | m_valid/m_ready    | bit_out, ones_total, found, found_position, range_error
//
//  read/write: index divide, one memory read, update (ST_DIV, ST_ADDR, ST_RMW, ST_DONE)
//  fill: one word write per cycle up to the map size
//  scan: read, mask and find-first per word visited; out-of-range requests skip the memory
//  one request is in work at a time
//  after reset and after a bits_in_use write a clearing pass zeroes
//  min(words, ceil(8192/WORD_BITS)) words (64 by default) with s_ready low
//  a finished result waits in the output register while the next request is taken
module bitmap_set_count_scan_top #(
    parameter int MAX_BITS  = bssc_pkg::MAX_BITS_DEF,
    parameter int WORD_BITS = bssc_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bssc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bssc_pkg::FIELD_W-1:0]     cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic [bssc_pkg::FIELD_W-1:0]     s_bit_index,
    input  logic                             s_bit_in,
    input  logic [bssc_pkg::FIELD_W-1:0]     s_fill_count,
    input  logic                             s_scan_restart,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_bit_out,
    output logic [bssc_pkg::FIELD_W-1:0]     m_ones_total,
    output logic                             m_found,
    output logic [bssc_pkg::FIELD_W-1:0]     m_found_position,
    output logic                             m_range_error
);
    import bssc_pkg::*;

    `include "bitmap_set_count_scan_top_defines.svh"

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int BW        = FIELD_W + 1;
    localparam int SPAN      = ((1 << FIELD_W) + WORD_BITS - 1) / WORD_BITS;
    localparam int CLR_WORDS = (NUM_WORDS < SPAN) ? NUM_WORDS : SPAN;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_DIV   = 10'b0000000100,
        ST_ADDR  = 10'b0000001000,
        ST_RMW   = 10'b0000010000,
        ST_FILL  = 10'b0000100000,
        ST_SREAD = 10'b0001000000,
        ST_SMASK = 10'b0010000000,
        ST_SCHK  = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_w_reg, clr_w_next;
    logic [FIELD_W-1:0] bits_reg, bits_next;
    logic               one_based_reg, one_based_next;
    logic [FIELD_W-1:0] ones_reg, ones_next;
    logic               started_reg, started_next;
    logic               exh_reg, exh_next;
    logic [AW-1:0]      cur_w_reg, cur_w_next;
    logic [OW-1:0]      cur_off_reg, cur_off_next;
    logic [BW-1:0]      cur_base_reg, cur_base_next;
    logic               m_valid_reg, m_valid_next;

    // payload
    action_t            act_reg, act_next;
    logic [FIELD_W-1:0] idx0_reg, idx0_next;
    logic               val_reg, val_next;
    logic [FIELD_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]      fill_w_reg, fill_w_next;
    logic [BW-1:0]      fill_base_reg, fill_base_next;
    logic [AW-1:0]      waddr_reg, waddr_next;
    logic [OW-1:0]      off_reg, off_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;

    // memory
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;

    logic [FIELD_W-1:0]   size_w;
    logic [BW-1:0]        size14;
    logic                 idx_bad;
    logic [FIELD_W-1:0]   idx0_w;
    logic [FIELD_W-1:0]   div_quot;
    logic [OW-1:0]        div_rem;
    logic [WORD_BITS-1:0] ffs_in;
    logic                 ffs_hit;
    logic [OW-1:0]        ffs_off;
    logic [WORD_BITS-1:0] fill_word;
    logic [WORD_BITS-1:0] scan_word;
    logic                 cur_bit;
    logic [WORD_BITS-1:0] upd_word;

    assign size_w    = (32'(bits_reg) > 32'(MAX_BITS)) ? FIELD_W'(MAX_BITS) : bits_reg;
    assign size14    = BW'(size_w);
    assign idx_bad   = one_based_reg && (s_bit_index == '0);
    assign idx0_w    = s_bit_index - FIELD_W'(one_based_reg);
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;

    bssc_wdiv #(.WORD_BITS(WORD_BITS)) u_wdiv (
        .aclk (aclk),
        .x    (idx0_reg),
        .quot (div_quot),
        .rem  (div_rem)
    );

    bssc_ffs #(.WORD_BITS(WORD_BITS)) u_ffs (
        .aclk    (aclk),
        .word_in (ffs_in),
        .hit     (ffs_hit),
        .offset  (ffs_off)
    );

    // fill pattern for the word at fill_base_reg
    always_comb begin
        logic [BW-1:0] cnt_rel;
        logic [BW-1:0] size_rel;
        cnt_rel  = (BW'(cnt_reg) > fill_base_reg) ? BW'(cnt_reg) - fill_base_reg : '0;
        size_rel = size14 - fill_base_reg;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (BW'(j) < cnt_rel) begin
                fill_word[j] = val_reg;
            end else if (BW'(j) < size_rel) begin
                fill_word[j] = !val_reg;
            end else begin
                fill_word[j] = 1'b0;
            end
        end
    end

    // keep bits from the scan cursor up to the map size
    always_comb begin
        logic [BW-1:0] lim;
        lim = size14 - cur_base_reg;
        for (int j = 0; j < WORD_BITS; j++) begin
            scan_word[j] = rdata_reg[j] && (j >= int'(cur_off_reg)) && (BW'(j) < lim);
        end
    end

    assign cur_bit = rdata_reg[off_reg];

    always_comb begin
        upd_word          = rdata_reg;
        upd_word[off_reg] = val_reg;
    end

    always_comb begin
        state_next     = state_reg;
        clr_w_next     = clr_w_reg;
        bits_next      = bits_reg;
        one_based_next = one_based_reg;
        ones_next      = ones_reg;
        started_next   = started_reg;
        exh_next       = exh_reg;
        cur_w_next     = cur_w_reg;
        cur_off_next   = cur_off_reg;
        cur_base_next  = cur_base_reg;
        m_valid_next   = m_valid_reg;
        act_next       = act_reg;
        idx0_next      = idx0_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        fill_w_next    = fill_w_reg;
        fill_base_next = fill_base_reg;
        waddr_next     = waddr_reg;
        off_next       = off_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_w_reg;
        mem_wdata      = fill_word;
        mem_raddr      = cur_w_reg;
        ffs_in         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_w_reg;
                mem_wdata = '0;
                if (clr_w_reg == AW'(CLR_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_w_next = clr_w_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    res_next = '0;
                    act_next = action_t'(s_action);
                    val_next = s_bit_in;
                    cnt_next = s_fill_count;
                    case (action_t'(s_action))
                        ACT_READ, ACT_WRITE: begin
                            idx0_next = idx0_w;
                            if (idx_bad || idx0_w >= size_w) begin
                                res_next.range_error = 1'b1;
                                state_next           = ST_DONE;
                            end else begin
                                state_next = ST_DIV;
                            end
                        end
                        ACT_FILL: begin
                            if (s_fill_count > size_w) begin
                                res_next.range_error = 1'b1;
                                state_next           = ST_DONE;
                            end else begin
                                ones_next      = s_bit_in ? s_fill_count
                                                          : size_w - s_fill_count;
                                fill_w_next    = '0;
                                fill_base_next = '0;
                                state_next     = ST_FILL;
                            end
                        end
                        ACT_SCAN: begin
                            if (s_scan_restart || !started_reg) begin
                                started_next  = 1'b1;
                                exh_next      = 1'b0;
                                cur_w_next    = '0;
                                cur_off_next  = '0;
                                cur_base_next = '0;
                                state_next    = ST_SREAD;
                            end else if (exh_reg) begin
                                state_next = ST_DONE;
                            end else begin
                                // resume one bit past the last one reported
                                if (cur_off_reg == OW'(WORD_BITS - 1)) begin
                                    cur_w_next    = cur_w_reg + AW'(1);
                                    cur_off_next  = '0;
                                    cur_base_next = cur_base_reg + BW'(WORD_BITS);
                                end else begin
                                    cur_off_next = cur_off_reg + OW'(1);
                                end
                                state_next = ST_SREAD;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                mem_raddr  = AW'(div_quot);
                waddr_next = AW'(div_quot);
                off_next   = div_rem;
                state_next = ST_RMW;
            end
            ST_RMW: begin
                if (act_reg == ACT_READ) begin
                    res_next.bit_out = cur_bit;
                end else if (cur_bit != val_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = upd_word;
                    ones_next = val_reg ? ones_reg + FIELD_W'(1) : ones_reg - FIELD_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_FILL: begin
                // words past the size already hold zero
                if (fill_base_reg >= size14) begin
                    state_next = ST_DONE;
                end else begin
                    mem_we         = 1'b1;
                    mem_waddr      = fill_w_reg;
                    mem_wdata      = fill_word;
                    fill_w_next    = fill_w_reg + AW'(1);
                    fill_base_next = fill_base_reg + BW'(WORD_BITS);
                end
            end
            ST_SREAD: begin
                if (cur_base_reg >= size14) begin
                    exh_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    mem_raddr  = cur_w_reg;
                    state_next = ST_SMASK;
                end
            end
            ST_SMASK: begin
                ffs_in     = scan_word;
                state_next = ST_SCHK;
            end
            ST_SCHK: begin
                if (ffs_hit) begin
                    cur_off_next            = ffs_off;
                    res_next.found          = 1'b1;
                    res_next.found_position = FIELD_W'(cur_base_reg + BW'(ffs_off)
                                                       + BW'(one_based_reg));
                    state_next              = ST_DONE;
                end else begin
                    cur_w_next    = cur_w_reg + AW'(1);
                    cur_off_next  = '0;
                    cur_base_next = cur_base_reg + BW'(WORD_BITS);
                    state_next    = ST_SREAD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next            = res_reg;
                    out_next.ones_total = ones_reg;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BITS_IN_USE: begin
                    // new size: empty map, count and scan start over
                    bits_next     = cfg_data;
                    ones_next     = '0;
                    started_next  = 1'b0;
                    exh_next      = 1'b0;
                    cur_w_next    = '0;
                    cur_off_next  = '0;
                    cur_base_next = '0;
                    clr_w_next    = '0;
                    state_next    = ST_CLEAR;
                end
                CFG_ONE_BASED: begin
                    one_based_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_w_reg     <= '0;
            bits_reg      <= BITS_RESET;
            one_based_reg <= 1'b0;
            ones_reg      <= '0;
            started_reg   <= 1'b0;
            exh_reg       <= 1'b0;
            cur_w_reg     <= '0;
            cur_off_reg   <= '0;
            cur_base_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_w_reg     <= clr_w_next;
            bits_reg      <= bits_next;
            one_based_reg <= one_based_next;
            ones_reg      <= ones_next;
            started_reg   <= started_next;
            exh_reg       <= exh_next;
            cur_w_reg     <= cur_w_next;
            cur_off_reg   <= cur_off_next;
            cur_base_reg  <= cur_base_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        idx0_reg      <= idx0_next;
        val_reg       <= val_next;
        cnt_reg       <= cnt_next;
        fill_w_reg    <= fill_w_next;
        fill_base_reg <= fill_base_next;
        waddr_reg     <= waddr_next;
        off_reg       <= off_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign m_valid          = m_valid_reg;
    assign m_bit_out        = out_reg.bit_out;
    assign m_ones_total     = out_reg.ones_total;
    assign m_found          = out_reg.found;
    assign m_found_position = out_reg.found_position;
    assign m_range_error    = out_reg.range_error;

    `BSSC_ASSERT_NOW(a_ones_within_size, aclk, aresetn, 1'b1, ones_reg <= size_w)
    `BSSC_ASSERT_NOW(a_found_below_size, aclk, aresetn,
        (state_reg == ST_SCHK) && ffs_hit, (cur_base_reg + BW'(ffs_off)) < size14)
    `BSSC_ASSERT_NOW(a_error_alone, aclk, aresetn,
        (state_reg == ST_DONE) && res_reg.range_error, !res_reg.found && !res_reg.bit_out)
    `BSSC_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

// ----- rtl/bssc_wdiv.sv -----
// splits a bit index into word address and bit offset (divide by WORD_BITS)
// reciprocal multiply registered, then one correction step; uses bssc_pkg
module bssc_wdiv #(
    parameter int WORD_BITS = bssc_pkg::WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic [bssc_pkg::FIELD_W-1:0]        x,
    output logic [bssc_pkg::FIELD_W-1:0]        quot,
    output logic [$clog2(WORD_BITS)-1:0]        rem
);
    import bssc_pkg::*;

    localparam int OW    = $clog2(WORD_BITS);
    localparam int SHIFT = FIELD_W + 7;
    localparam int RECIP = (1 << SHIFT) / WORD_BITS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = FIELD_W + RW;

    logic [PW-1:0]      prod;
    logic [FIELD_W-1:0] q0_reg;
    logic [FIELD_W-1:0] x_reg;
    logic [FIELD_W-1:0] back;
    logic [FIELD_W-1:0] r0;

    assign prod = PW'(x) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        q0_reg <= FIELD_W'(prod >> SHIFT);
        x_reg  <= x;
    end

    // estimate is at most one low
    assign back = q0_reg * FIELD_W'(WORD_BITS);
    assign r0   = x_reg - back;

    always_comb begin
        if (r0 >= FIELD_W'(WORD_BITS)) begin
            quot = q0_reg + FIELD_W'(1);
            rem  = OW'(r0 - FIELD_W'(WORD_BITS));
        end else begin
            quot = q0_reg;
            rem  = OW'(r0);
        end
    end

endmodule

// ----- rtl/bssc_ffs.sv -----
// lowest set bit of one word, two levels: byte groups registered, then group pick
// uses bssc_pkg for the group width
module bssc_ffs #(
    parameter int WORD_BITS = bssc_pkg::WORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic [WORD_BITS-1:0]         word_in,
    output logic                         hit,
    output logic [$clog2(WORD_BITS)-1:0] offset
);
    import bssc_pkg::*;

    localparam int OW    = $clog2(WORD_BITS);
    localparam int NGRP  = (WORD_BITS + GRP_W - 1) / GRP_W;
    localparam int PAD_W = NGRP * GRP_W;
    localparam int GPW   = $clog2(GRP_W);

    logic [PAD_W-1:0] padded;
    logic             grp_any      [NGRP];
    logic [GPW-1:0]   grp_pos      [NGRP];
    logic             grp_any_reg  [NGRP];
    logic [GPW-1:0]   grp_pos_reg  [NGRP];

    assign padded = PAD_W'(word_in);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = |padded[g*GRP_W +: GRP_W];
            grp_pos[g] = '0;
            for (int j = GRP_W - 1; j >= 0; j--) begin
                if (padded[g*GRP_W + j]) begin
                    grp_pos[g] = GPW'(j);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_reg[g] <= grp_any[g];
            grp_pos_reg[g] <= grp_pos[g];
        end
    end

    always_comb begin
        hit    = 1'b0;
        offset = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                hit    = 1'b1;
                offset = OW'(g * GRP_W + int'(grp_pos_reg[g]));
            end
        end
    end

endmodule

// ----- tb/sv/tb_bitmap_set_count_scan_top.sv -----
// self-checking testbench for bitmap_set_count_scan_top: read, write, fill and
// set-bit scan requests checked field by field against an in-bench bit map predictor
// depends on bssc_pkg and the bitmap_set_count_scan_top rtl
`timescale 1ns / 100ps

module tb_bitmap_set_count_scan_top;
    import bssc_pkg::*;

    localparam int LIMIT_CYCLES  = 1500000;
    localparam int SETTLE_CYCLES = 250;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = CFG_BITS_IN_USE;
    logic [FIELD_W-1:0]   cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action         = ACT_READ;
    logic [FIELD_W-1:0]   s_bit_index      = '0;
    logic                 s_bit_in         = 1'b0;
    logic [FIELD_W-1:0]   s_fill_count     = '0;
    logic                 s_scan_restart   = 1'b0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic                 m_bit_out;
    logic [FIELD_W-1:0]   m_ones_total;
    logic                 m_found;
    logic [FIELD_W-1:0]   m_found_position;
    logic                 m_range_error;

    // predicted map state and register copies
    bit          map_bits [MAX_BITS_DEF];
    int unsigned ones_cnt;
    int unsigned scan_at;
    bit          scan_on;
    bit          scan_done;
    int unsigned size_reg  = BITS_RESET;
    bit          base_one  = 1'b0;

    result_t     pending_results [$];
    bit          offering        = 1'b0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned hold_request    = 0;
    int unsigned hold_left       = 0;
    int unsigned cycle_count     = 0;
    int unsigned error_count     = 0;
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;

    bitmap_set_count_scan_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_bit_index      (s_bit_index),
        .s_bit_in         (s_bit_in),
        .s_fill_count     (s_fill_count),
        .s_scan_restart   (s_scan_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bit_out        (m_bit_out),
        .m_ones_total     (m_ones_total),
        .m_found          (m_found),
        .m_found_position (m_found_position),
        .m_range_error    (m_range_error)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("bitmap_set_count_scan_top verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold when a test asks for one
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_checked, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_ready && m_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_bit_out !== want.bit_out)
                    report_mismatch("bit_out", m_bit_out, want.bit_out);
                if (m_ones_total !== want.ones_total)
                    report_mismatch("ones_total", m_ones_total, want.ones_total);
                if (m_found !== want.found)
                    report_mismatch("found", m_found, want.found);
                if (m_found_position !== want.found_position)
                    report_mismatch("found_position", m_found_position, want.found_position);
                if (m_range_error !== want.range_error)
                    report_mismatch("range_error", m_range_error, want.range_error);
            end
            results_checked++;
        end
    end

    function automatic int unsigned active_size();
        return (size_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : size_reg;
    endfunction

    function automatic void clear_map();
        foreach (map_bits[p]) map_bits[p] = 1'b0;
        ones_cnt  = 0;
        scan_at   = 0;
        scan_on   = 1'b0;
        scan_done = 1'b0;
    endfunction

    // updates the predicted map and returns the result of one request
    function automatic result_t predict_request(action_t act, logic [FIELD_W-1:0] idx,
                                                logic val, logic [FIELD_W-1:0] cnt,
                                                logic restart);
        result_t     r;
        int unsigned size;
        int unsigned pos;
        int unsigned first;
        int unsigned fill_n;
        bit          bad;
        bit          search;
        r      = '0;
        size   = active_size();
        fill_n = cnt;
        case (act)
            ACT_READ, ACT_WRITE: begin
                bad = base_one && (idx == 0);
                pos = bad ? 0 : int'(idx) - int'(base_one);
                if (bad || pos >= size) begin
                    r.range_error = 1'b1;
                end else if (act == ACT_READ) begin
                    r.bit_out = map_bits[pos];
                end else if (map_bits[pos] != val) begin
                    map_bits[pos] = val;
                    ones_cnt = val ? ones_cnt + 1 : ones_cnt - 1;
                end
            end
            ACT_FILL: begin
                if (fill_n > size) begin
                    r.range_error = 1'b1;
                end else begin
                    for (pos = 0; pos < MAX_BITS_DEF; pos++)
                        map_bits[pos] = (pos < size) ? ((pos < fill_n) ? val : !val) : 1'b0;
                    ones_cnt = val ? fill_n : size - fill_n;
                end
            end
            default: begin
                if (restart) begin
                    scan_on   = 1'b0;
                    scan_done = 1'b0;
                    scan_at   = 0;
                end
                search = 1'b1;
                first  = 0;
                if (!scan_on)
                    scan_on = 1'b1;
                else if (scan_done)
                    search = 1'b0;
                else
                    first = scan_at + 1;
                if (search) begin
                    pos = first;
                    while (pos < size && !map_bits[pos]) pos++;
                    if (pos < size) begin
                        scan_at          = pos;
                        r.found          = 1'b1;
                        r.found_position = FIELD_W'(pos + base_one);
                    end else begin
                        scan_done = 1'b1;
                    end
                end
            end
        endcase
        r.ones_total = FIELD_W'(ones_cnt);
        return r;
    endfunction

    // offers one request, holding it until the transfer; valid is left high so the
    // next request can follow without a bubble
    task automatic send_request(action_t act, logic [FIELD_W-1:0] idx, logic val,
                                logic [FIELD_W-1:0] cnt, logic restart);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            if (offering) begin
                s_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_bit_index    <= idx;
        s_bit_in       <= val;
        s_fill_count   <= cnt;
        s_scan_restart <= restart;
        offering = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_request(act, idx, val, cnt, restart));
        requests_sent++;
    endtask

    task automatic wait_all_results();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(cfg_reg_t which, logic [FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (which == CFG_BITS_IN_USE) begin
            size_reg = value;
            clear_map();
        end else begin
            base_one = value[0];
        end
        reg_writes++;
    endtask

    // registers change only with the block drained
    task automatic program_registers(bit set_size, int unsigned size_val,
                                     bit set_base, bit base_val);
        logic [FIELD_W-2:0] junk;
        wait_all_results();
        junk = $urandom_range(4095);
        if (set_size)
            write_register(CFG_BITS_IN_USE, FIELD_W'(size_val));
        if (set_base)
            write_register(CFG_ONE_BASED, {junk, base_val});
        cfg_valid <= 1'b0;
    endtask

    // mostly in range, some at the edges, the rest anywhere in the field
    function automatic logic [FIELD_W-1:0] pick_value(int lo, int hi);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 65 && hi >= lo)
            return FIELD_W'($urandom_range(hi, lo));
        if (sel < 82) begin
            case ($urandom_range(3))
                0:       return FIELD_W'(lo);
                1:       return FIELD_W'(hi);
                2:       return FIELD_W'(hi + 1);
                default: return FIELD_W'(lo - 1);
            endcase
        end
        return FIELD_W'($urandom_range(8191));
    endfunction

    task automatic send_random_request();
        int unsigned sel;
        int          size;
        action_t     act;
        sel  = $urandom_range(99);
        size = active_size();
        act  = (sel < 28) ? ACT_READ : (sel < 58) ? ACT_WRITE : (sel < 68) ? ACT_FILL : ACT_SCAN;
        send_request(act, pick_value(base_one, size - 1 + base_one), $urandom_range(1),
                     pick_value(0, size), ($urandom_range(99) < 12));
    endtask

    task automatic test_reset_defaults();
        send_request(ACT_READ,  13'd0,    1'b0, 13'd0,    1'b0);
        send_request(ACT_READ,  13'd4095, 1'b0, 13'd0,    1'b0);
        send_request(ACT_READ,  13'd4096, 1'b0, 13'd0,    1'b0);
        // empty map: first scan exhausts, a later set bit stays unseen until restart
        send_request(ACT_SCAN,  13'd0,    1'b0, 13'd0,    1'b0);
        send_request(ACT_WRITE, 13'd4095, 1'b1, 13'd0,    1'b0);
        send_request(ACT_SCAN,  13'd0,    1'b0, 13'd0,    1'b0);
        send_request(ACT_SCAN,  13'd0,    1'b0, 13'd0,    1'b1);
        send_request(ACT_WRITE, 13'd8191, 1'b1, 13'd8191, 1'b1);
        send_request(ACT_FILL,  13'd0,    1'b1, 13'd4096, 1'b0);
        send_request(ACT_READ,  13'd4095, 1'b1, 13'd0,    1'b1);
        send_request(ACT_FILL,  13'd0,    1'b0, 13'd4097, 1'b0);
    endtask

    task automatic test_one_based_edges();
        program_registers(1'b1, 100, 1'b1, 1'b1);
        send_request(ACT_WRITE, 13'd0,   1'b1, 13'd0,   1'b0);
        send_request(ACT_WRITE, 13'd100, 1'b1, 13'd0,   1'b0);
        send_request(ACT_WRITE, 13'd101, 1'b1, 13'd0,   1'b0);
        send_request(ACT_READ,  13'd100, 1'b0, 13'd0,   1'b0);
        send_request(ACT_SCAN,  13'd0,   1'b0, 13'd0,   1'b1);
        // fill leaves the scan where it was, so the next scan runs off the end
        send_request(ACT_FILL,  13'd0,   1'b0, 13'd0,   1'b0);
        send_request(ACT_SCAN,  13'd0,   1'b0, 13'd0,   1'b0);
        send_request(ACT_SCAN,  13'd0,   1'b0, 13'd0,   1'b1);
        send_request(ACT_FILL,  13'd0,   1'b1, 13'd101, 1'b0);
        send_request(ACT_WRITE, 13'd1,   1'b0, 13'd0,   1'b0);
    endtask

    task automatic test_zero_size();
        program_registers(1'b1, 0, 1'b1, 1'b0);
        send_request(ACT_SCAN, 13'd0, 1'b0, 13'd0, 1'b1);
        send_request(ACT_FILL, 13'd0, 1'b0, 13'd0, 1'b0);
        send_request(ACT_FILL, 13'd0, 1'b1, 13'd1, 1'b0);
        send_request(ACT_READ, 13'd0, 1'b0, 13'd0, 1'b0);
    endtask

    task automatic run_random_phase(bit set_size, int unsigned size_val, bit base_val,
                                    int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned n_items);
        program_registers(set_size, size_val, 1'b1, base_val);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) send_random_request();
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b1, 64,   1'b0, 0,  0,  130);
        run_random_phase(1'b1, 4096, 1'b1, 58, 0,  130);
        run_random_phase(1'b1, 1,    1'b0, 0,  58, 90);
        run_random_phase(1'b1, 8191, 1'b0, 18, 18, 130);
        run_random_phase(1'b1, 100,  1'b1, 58, 0,  130);
        run_random_phase(1'b1, 200,  1'b0, 0,  58, 130);
        run_random_phase(1'b1, 4095, 1'b1, 18, 18, 130);
        run_random_phase(1'b1, 63,   1'b1, 0,  0,  130);
        // switch index base only, keeping the map contents
        run_random_phase(1'b0, 0,    1'b0, 18, 18, 100);
    endtask

    // long output hold while requests keep coming, so the block backs up
    task automatic test_result_backpressure();
        program_registers(1'b1, 64, 1'b1, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (16) send_random_request();
    endtask

    initial begin
        clear_map();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_one_based_edges();
        test_zero_size();
        test_result_backpressure();
        test_random_traffic();

        wait_all_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run summary: %0d requests, %0d results checked, %0d register writes",
                 requests_sent, results_checked, reg_writes);
        $display("run summary: all four actions, sizes from 0 to 8191, both index bases,"
                 , " input gaps, output stalls and a long output hold");
        if (error_count == 0) begin
            $display("bitmap_set_count_scan_top verification clean");
        end else begin
            $display("bitmap_set_count_scan_top verification failed");
        end
        $finish;
    end

endmodule
